### hw/rtl/krle_pkg.sv
// ----------------------------------------------------------------------------
// krle_pkg: shared types and constants of the keyed record list engine
// Record layout, operation and status codes, and the command and flag
// groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package krle_pkg;

	localparam int CAPACITY = 64;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = 7;
	localparam int WW = (CW > PW) ? CW : PW;

	localparam logic [2:0] MODE_APPEND = 3'd0;
	localparam logic [2:0] MODE_INSERT = 3'd1;
	localparam logic [2:0] MODE_MODIFY = 3'd2;
	localparam logic [2:0] MODE_DELETE = 3'd3;
	localparam logic [2:0] MODE_SORT   = 3'd4;
	localparam logic [2:0] MODE_READ   = 3'd5;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_FULL   = 3'd1;
	localparam logic [2:0] ST_BADPOS = 3'd2;
	localparam logic [2:0] ST_DUP    = 3'd3;
	localparam logic [2:0] ST_NOKEY  = 3'd4;

	typedef struct packed {
		logic [31:0] key;
		logic [63:0] payload;
		logic [15:0] duration;
	} rec_t;

	typedef enum logic [2:0] {RA_IDX, RA_IDX_P1, RA_IDX_M1, RA_POS, RA_ZERO} rd_addr_t;
	typedef enum logic {WA_IDX, WA_POS} wr_addr_t;
	typedef enum logic [1:0] {WD_RD, WD_CARRY, WD_NEW, WD_MOD} wr_data_t;
	typedef enum logic [2:0] {IX_HOLD, IX_ZERO, IX_LEN, IX_INC, IX_DEC} idx_op_t;
	typedef enum logic [1:0] {LM_HOLD, LM_LOAD, LM_DEC} lim_op_t;
	typedef enum logic [1:0] {LN_HOLD, LN_INC, LN_DEC} len_op_t;

	typedef struct packed {
		logic      load;
		logic      rd_en;
		rd_addr_t  rd_addr;
		logic      wr_en;
		wr_addr_t  wr_addr;
		wr_data_t  wr_data;
		idx_op_t   idx_op;
		lim_op_t   lim_op;
		len_op_t   len_op;
		logic      carry_ld;
		logic      finish;
		logic [2:0] status;
		logic      found_en;
	} cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic full;
		logic pos_gt_len;
		logic pos_ge_len;
		logic len_zero;
		logic len_lt2;
		logic key_hit;
		logic search_last;
		logic idx_gt_pos;
		logic idx_p1_lt_len;
		logic idx_lt_lim;
		logic lim_is1;
		logic carry_gt;
	} flags_t;

endpackage

### hw/rtl/krle_ctrl.sv
// ----------------------------------------------------------------------------
// krle_ctrl: operation sequencer
// Walks search, shift, sort-pass and read sequences one memory access a
// step and issues datapath commands.
// ----------------------------------------------------------------------------
module krle_ctrl import krle_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  logic   out_busy,
	input  flags_t flg,
	output cmd_t   cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DEC    = 4'd1;
	localparam logic [3:0] S_SRD    = 4'd2;
	localparam logic [3:0] S_SCMP   = 4'd3;
	localparam logic [3:0] S_ICHK   = 4'd4;
	localparam logic [3:0] S_IWR    = 4'd5;
	localparam logic [3:0] S_DCHK   = 4'd6;
	localparam logic [3:0] S_DWR    = 4'd7;
	localparam logic [3:0] S_PSTART = 4'd8;
	localparam logic [3:0] S_PLOAD  = 4'd9;
	localparam logic [3:0] S_PRD    = 4'd10;
	localparam logic [3:0] S_PCMP   = 4'd11;
	localparam logic [3:0] S_RDONE  = 4'd12;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = !out_busy;
				if (in_valid && !out_busy) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				unique case (flg.mode)
					MODE_APPEND, MODE_INSERT: begin
						priority if (flg.full) begin
							cmd.finish = 1'b1;
							cmd.status = ST_FULL;
							state_d    = S_IDLE;
						end else if (flg.mode == MODE_INSERT && flg.pos_gt_len) begin
							cmd.finish = 1'b1;
							cmd.status = ST_BADPOS;
							state_d    = S_IDLE;
						end else if (flg.len_zero) begin
							cmd.idx_op = IX_LEN;
							state_d    = S_ICHK;
						end else begin
							cmd.idx_op = IX_ZERO;
							state_d    = S_SRD;
						end
					end
					MODE_MODIFY, MODE_DELETE: begin
						if (flg.len_zero) begin
							cmd.finish = 1'b1;
							cmd.status = ST_NOKEY;
							state_d    = S_IDLE;
						end else begin
							cmd.idx_op = IX_ZERO;
							state_d    = S_SRD;
						end
					end
					MODE_SORT: begin
						if (flg.len_lt2) begin
							cmd.finish = 1'b1;
							cmd.status = ST_OK;
							state_d    = S_IDLE;
						end else begin
							cmd.lim_op = LM_LOAD;
							state_d    = S_PSTART;
						end
					end
					MODE_READ: begin
						if (flg.pos_ge_len) begin
							cmd.finish = 1'b1;
							cmd.status = ST_BADPOS;
							state_d    = S_IDLE;
						end else begin
							cmd.rd_en   = 1'b1;
							cmd.rd_addr = RA_POS;
							state_d     = S_RDONE;
						end
					end
					default: begin
						cmd.finish = 1'b1;
						cmd.status = ST_OK;
						state_d    = S_IDLE;
					end
				endcase
			end
			S_SRD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = RA_IDX;
				state_d     = S_SCMP;
			end
			S_SCMP: begin
				priority if (flg.key_hit) begin
					if (flg.mode == MODE_DELETE) begin
						state_d = S_DCHK;
					end else begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
						if (flg.mode == MODE_MODIFY) begin
							cmd.wr_en   = 1'b1;
							cmd.wr_addr = WA_IDX;
							cmd.wr_data = WD_MOD;
							cmd.status  = ST_OK;
						end else begin
							cmd.status = ST_DUP;
						end
					end
				end else if (flg.search_last) begin
					if (flg.mode == MODE_APPEND || flg.mode == MODE_INSERT) begin
						cmd.idx_op = IX_LEN;
						state_d    = S_ICHK;
					end else begin
						cmd.finish = 1'b1;
						cmd.status = ST_NOKEY;
						state_d    = S_IDLE;
					end
				end else begin
					cmd.idx_op = IX_INC;
					state_d    = S_SRD;
				end
			end
			S_ICHK: begin
				if (flg.idx_gt_pos) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = RA_IDX_M1;
					state_d     = S_IWR;
				end else begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = WA_POS;
					cmd.wr_data = WD_NEW;
					cmd.len_op  = LN_INC;
					cmd.finish  = 1'b1;
					cmd.status  = ST_OK;
					state_d     = S_IDLE;
				end
			end
			S_IWR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = WA_IDX;
				cmd.wr_data = WD_RD;
				cmd.idx_op  = IX_DEC;
				state_d     = S_ICHK;
			end
			S_DCHK: begin
				if (flg.idx_p1_lt_len) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = RA_IDX_P1;
					state_d     = S_DWR;
				end else begin
					cmd.len_op = LN_DEC;
					cmd.finish = 1'b1;
					cmd.status = ST_OK;
					state_d    = S_IDLE;
				end
			end
			S_DWR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = WA_IDX;
				cmd.wr_data = WD_RD;
				cmd.idx_op  = IX_INC;
				state_d     = S_DCHK;
			end
			S_PSTART: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = RA_ZERO;
				cmd.idx_op  = IX_ZERO;
				state_d     = S_PLOAD;
			end
			S_PLOAD: begin
				cmd.carry_ld = 1'b1;
				state_d      = S_PRD;
			end
			S_PRD: begin
				if (flg.idx_lt_lim) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = RA_IDX_P1;
					state_d     = S_PCMP;
				end else begin
					// end of pass: the carried record settles at the top
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = WA_IDX;
					cmd.wr_data = WD_CARRY;
					cmd.lim_op  = LM_DEC;
					if (flg.lim_is1) begin
						cmd.finish = 1'b1;
						cmd.status = ST_OK;
						state_d    = S_IDLE;
					end else begin
						state_d = S_PSTART;
					end
				end
			end
			S_PCMP: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = WA_IDX;
				cmd.idx_op  = IX_INC;
				if (flg.carry_gt) begin
					cmd.wr_data = WD_RD;
				end else begin
					cmd.wr_data  = WD_CARRY;
					cmd.carry_ld = 1'b1;
				end
				state_d = S_PRD;
			end
			S_RDONE: begin
				cmd.finish   = 1'b1;
				cmd.status   = ST_OK;
				cmd.found_en = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/krle_dpath.sv
// ----------------------------------------------------------------------------
// krle_dpath: record memory, index counters and result register
// One write port and one registered read port on the record array.
// ----------------------------------------------------------------------------
module krle_dpath import krle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output flags_t      flg,
	input  logic [2:0]  in_mode,
	input  logic [6:0]  in_position,
	input  logic [31:0] in_search_key,
	input  logic [31:0] in_replacement_key,
	input  logic [63:0] in_record_payload,
	input  logic [15:0] in_record_duration,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [2:0]  status,
	output logic [31:0] found_key,
	output logic [63:0] found_payload,
	output logic [15:0] found_duration,
	output logic [6:0]  entry_total
);

	rec_t rec_mem [CAPACITY];

	logic [2:0]    mode_q;
	logic [6:0]    pos_q;
	logic [31:0]   skey_q, rkey_q;
	logic [63:0]   pay_q;
	logic [15:0]   dur_q;
	logic [CW-1:0] len_q, len_d, idx_q, lim_q;
	logic [CW-1:0] idx_p1, pos_eff;
	rec_t          rd_q, carry_q, wr_rec;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          out_valid_q;

	assign idx_p1  = idx_q + CW'(1);
	assign pos_eff = (mode_q == MODE_APPEND) ? len_q : CW'(pos_q);

	always_comb begin
		flg.mode          = mode_q;
		flg.full          = len_q >= CW'(CAPACITY);
		flg.pos_gt_len    = WW'(pos_q) > WW'(len_q);
		flg.pos_ge_len    = WW'(pos_q) >= WW'(len_q);
		flg.len_zero      = len_q == '0;
		flg.len_lt2       = len_q < CW'(2);
		flg.key_hit       = rd_q.key == skey_q;
		flg.search_last   = idx_p1 == len_q;
		flg.idx_gt_pos    = idx_q > pos_eff;
		flg.idx_p1_lt_len = idx_p1 < len_q;
		flg.idx_lt_lim    = idx_q < lim_q;
		flg.lim_is1       = lim_q == CW'(1);
		flg.carry_gt      = carry_q.duration > rd_q.duration;
	end

	always_comb begin
		unique case (cmd.rd_addr)
			RA_IDX:    rd_addr = AW'(idx_q);
			RA_IDX_P1: rd_addr = AW'(idx_p1);
			RA_IDX_M1: rd_addr = AW'(idx_q - CW'(1));
			RA_POS:    rd_addr = AW'(pos_q);
			default:   rd_addr = '0;
		endcase
	end

	assign wr_addr = (cmd.wr_addr == WA_POS) ? AW'(pos_eff) : AW'(idx_q);

	always_comb begin
		unique case (cmd.wr_data)
			WD_RD:    wr_rec = rd_q;
			WD_CARRY: wr_rec = carry_q;
			WD_NEW:   wr_rec = '{key: skey_q, payload: pay_q, duration: 16'd0};
			WD_MOD:   wr_rec = '{key: rkey_q, payload: pay_q, duration: dur_q};
			default:  wr_rec = rd_q;
		endcase
	end

	always_comb begin
		unique case (cmd.len_op)
			LN_INC:  len_d = len_q + CW'(1);
			LN_DEC:  len_d = len_q - CW'(1);
			default: len_d = len_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			rec_mem[wr_addr] <= wr_rec;
		end
		if (cmd.rd_en) begin
			rd_q <= rec_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			pos_q  <= in_position;
			skey_q <= in_search_key;
			rkey_q <= in_replacement_key;
			pay_q  <= in_record_payload;
			dur_q  <= in_record_duration;
		end
		if (cmd.carry_ld) begin
			carry_q <= rd_q;
		end
		if (cmd.finish) begin
			status         <= cmd.status;
			found_key      <= cmd.found_en ? rd_q.key : 32'd0;
			found_payload  <= cmd.found_en ? rd_q.payload : 64'd0;
			found_duration <= cmd.found_en ? rd_q.duration : 16'd0;
			entry_total    <= 7'(len_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			idx_q       <= '0;
			lim_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			len_q <= len_d;
			unique case (cmd.idx_op)
				IX_ZERO: idx_q <= '0;
				IX_LEN:  idx_q <= len_q;
				IX_INC:  idx_q <= idx_p1;
				IX_DEC:  idx_q <= idx_q - CW'(1);
				default: idx_q <= idx_q;
			endcase
			unique case (cmd.lim_op)
				LM_LOAD: lim_q <= len_q - CW'(1);
				LM_DEC:  lim_q <= lim_q - CW'(1);
				default: lim_q <= lim_q;
			endcase
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hw/rtl/keyed_record_list_engine.sv
// ----------------------------------------------------------------------------
// keyed_record_list_engine: ordered record list with keyed operations
// Append, insert, modify, delete, sort by duration and read on a list of
// up to CAPACITY records held in one on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one operation item: tuser is the mode, tdata the operands.
//   m_* returns exactly one result item per operation.
//   One item is in work at a time; s_tready is low from acceptance until
//   the result has been taken on m_*.
// Sequencing (n = entries held, from acceptance to m_tvalid):
//   read: one memory read, then the result
//   full/bad-position/empty-list rejects, unused modes: answered at decode
//   key search: each entry visited is read, then compared
//   insert/delete shift: each entry moved is read, then written one place over
//   sort: n-1 bubble passes on duration, each carrying the larger record up
// A stalled m_tready holds the result register; the next item is taken
// once it has drained. Reset empties the list; the memory holds no reset.
// ----------------------------------------------------------------------------
module keyed_record_list_engine import krle_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// position, search_key, replacement_key, record_payload, record_duration
	input  logic [151:0] s_tdata,
	// mode
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status, found_key, found_payload, found_duration, entry_total
	output logic [127:0] m_tdata
);

	cmd_t   cmd;
	flags_t flg;
	logic [2:0]  status;
	logic [31:0] found_key;
	logic [63:0] found_payload;
	logic [15:0] found_duration;
	logic [6:0]  entry_total;

	krle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_busy (m_tvalid),
		.flg      (flg),
		.cmd      (cmd)
	);

	krle_dpath u_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.flg                (flg),
		.in_mode            (s_tuser),
		.in_position        (s_tdata[6:0]),
		.in_search_key      (s_tdata[38:7]),
		.in_replacement_key (s_tdata[70:39]),
		.in_record_payload  (s_tdata[134:71]),
		.in_record_duration (s_tdata[150:135]),
		.out_ready          (m_tready),
		.out_valid          (m_tvalid),
		.status             (status),
		.found_key          (found_key),
		.found_payload      (found_payload),
		.found_duration     (found_duration),
		.entry_total        (entry_total)
	);

	assign m_tdata = {6'd0, entry_total, found_duration, found_payload, found_key, status};

endmodule

### hw/rtl/krle_checker.sv
// ----------------------------------------------------------------------------
// krle_checker: port-level checks of the record list engine
// Watches the stream ports and flags result and handshake slips.
// ----------------------------------------------------------------------------
module krle_checker import krle_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item dropped or changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input taken while a result waits");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= ST_NOKEY)
		else $error("status code out of range");

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[121:115] <= 7'(CAPACITY))
		else $error("entry total above capacity");

endmodule

bind keyed_record_list_engine krle_checker u_krle_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for keyed_record_list_engine
// Drives operation items on the slave stream, predicts each result with a
// local model of the record list or takes it from the directed table, and
// compares field by field. A directed table and a fill to capacity run
// first, then random traffic in four phases, one with a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import krle_pkg::*;

	localparam int  RAND_PER_PHASE = 130;
	localparam int  HOLD_CYCLES    = 3000;
	localparam int  CYCLE_LIMIT    = 3000000;
	localparam int  KEY_POOL       = 96;
	localparam logic [2:0] MODE_SPARE = 3'd6;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] key;
		logic [63:0] payload;
		logic [15:0] duration;
		logic [6:0]  total;
	} result_t;

	typedef struct {
		logic [2:0]  mode;
		logic [6:0]  pos;
		logic [31:0] skey;
		logic [31:0] rkey;
		logic [63:0] pay;
		logic [15:0] dur;
		bit          typed;
		result_t     res;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [151:0] s_tdata;
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;

	// local copy of the list
	logic [31:0] list_key [CAPACITY];
	logic [63:0] list_pay [CAPACITY];
	logic [15:0] list_dur [CAPACITY];
	int          list_len;

	result_t     pending_results[$];
	logic [31:0] key_pool [KEY_POOL];
	int          errors;
	int          cycles;
	int          phase;
	int          idle_pct;
	int          stall_pct;
	int          hold_left;

	keyed_record_list_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int find_key(logic [31:0] k);
		for (int i = 0; i < list_len; i++)
			if (list_key[i] == k) return i;
		return -1;
	endfunction

	function automatic result_t apply_op(logic [2:0] mode, logic [6:0] pos_in,
			logic [31:0] skey, logic [31:0] rkey, logic [63:0] pay, logic [15:0] dur);
		result_t r;
		int      pos;
		int      idx;
		logic [31:0] tk;
		logic [63:0] tp;
		logic [15:0] td;
		r = '0;
		pos = pos_in;
		case (mode)
			MODE_APPEND, MODE_INSERT: begin
				if (list_len >= CAPACITY) r.status = ST_FULL;
				else begin
					if (mode == MODE_APPEND) pos = list_len;
					if (pos > list_len) r.status = ST_BADPOS;
					else if (find_key(skey) >= 0) r.status = ST_DUP;
					else begin
						for (int i = list_len; i > pos; i--) begin
							list_key[i] = list_key[i-1];
							list_pay[i] = list_pay[i-1];
							list_dur[i] = list_dur[i-1];
						end
						list_key[pos] = skey;
						list_pay[pos] = pay;
						list_dur[pos] = '0;
						list_len++;
					end
				end
			end
			MODE_MODIFY: begin
				idx = find_key(skey);
				if (idx < 0) r.status = ST_NOKEY;
				else begin
					list_key[idx] = rkey;
					list_pay[idx] = pay;
					list_dur[idx] = dur;
				end
			end
			MODE_DELETE: begin
				idx = find_key(skey);
				if (idx < 0) r.status = ST_NOKEY;
				else begin
					for (int j = idx; j + 1 < list_len; j++) begin
						list_key[j] = list_key[j+1];
						list_pay[j] = list_pay[j+1];
						list_dur[j] = list_dur[j+1];
					end
					list_len--;
				end
			end
			MODE_SORT: begin
				for (int i = 0; i + 1 < list_len; i++)
					for (int j = 0; j + 1 < list_len - i; j++)
						if (list_dur[j] > list_dur[j+1]) begin
							tk = list_key[j]; tp = list_pay[j]; td = list_dur[j];
							list_key[j] = list_key[j+1];
							list_pay[j] = list_pay[j+1];
							list_dur[j] = list_dur[j+1];
							list_key[j+1] = tk; list_pay[j+1] = tp; list_dur[j+1] = td;
						end
			end
			MODE_READ: begin
				if (pos >= list_len) r.status = ST_BADPOS;
				else begin
					r.key = list_key[pos];
					r.payload = list_pay[pos];
					r.duration = list_dur[pos];
				end
			end
			default: ;
		endcase
		r.total = list_len[6:0];
		return r;
	endfunction

	// offer one item, wait for acceptance, then record what it should produce
	task automatic send_op(row_t op);
		result_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op.mode;
		s_tdata  <= {1'b0, op.dur, op.pay, op.rkey, op.skey, op.pos};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		predicted = apply_op(op.mode, op.pos, op.skey, op.rkey, op.pay, op.dur);
		pending_results.push_back(op.typed ? op.res : predicted);
	endtask

	function automatic row_t mk(logic [2:0] mode, logic [6:0] pos, logic [31:0] skey,
			logic [31:0] rkey, logic [63:0] pay, logic [15:0] dur);
		row_t r;
		r.mode = mode; r.pos = pos; r.skey = skey; r.rkey = rkey;
		r.pay = pay; r.dur = dur; r.typed = 1'b0; r.res = '0;
		return r;
	endfunction

	function automatic row_t mkx(row_t r, logic [2:0] st, logic [31:0] k,
			logic [63:0] p, logic [15:0] d, logic [6:0] tot);
		r.typed = 1'b1;
		r.res = '{status: st, key: k, payload: p, duration: d, total: tot};
		return r;
	endfunction

	function automatic logic [31:0] pick_key();
		if ($urandom_range(99) < 85) return key_pool[$urandom_range(KEY_POOL - 1)];
		return $urandom;
	endfunction

	function automatic row_t random_op();
		row_t r;
		int   w;
		r = mk(MODE_APPEND, '0, pick_key(), pick_key(), {$urandom, $urandom},
			($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(7)));
		w = $urandom_range(99);
		// steer away from appends and inserts when the list runs long, so length swings
		if (list_len > 48 && w < 30) w = 50 + w % 15;
		if (w < 28)      r.mode = MODE_APPEND;
		else if (w < 48) r.mode = MODE_INSERT;
		else if (w < 62) r.mode = MODE_MODIFY;
		else if (w < 78) r.mode = MODE_DELETE;
		else if (w < 81) r.mode = MODE_SORT;
		else if (w < 98) r.mode = MODE_READ;
		else             r.mode = MODE_SPARE | 3'($urandom_range(1));
		if ($urandom_range(99) < 88)
			r.pos = 7'($urandom_range(list_len));
		else
			r.pos = 7'($urandom_range(127));
		if (r.mode == MODE_READ && list_len > 0 && $urandom_range(99) < 85)
			r.pos = 7'($urandom_range(list_len - 1));
		if ((r.mode == MODE_MODIFY || r.mode == MODE_DELETE) && list_len > 0
				&& $urandom_range(99) < 70)
			r.skey = list_key[$urandom_range(list_len - 1)];
		return r;
	endfunction

	// output side: random stall, with one long hold-off in phase 2
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (phase == 2 && hold_left < 0) hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// result checker; handshake signals settle between edges
	always @(negedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{status: m_tdata[2:0], key: m_tdata[34:3], payload: m_tdata[98:35],
				duration: m_tdata[114:99], total: m_tdata[121:115]};
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result item %h", $time, m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status) begin
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
					errors++;
				end
				if (got.key !== want.key) begin
					$display("%0t: found_key exp %h got %h", $time, want.key, got.key);
					errors++;
				end
				if (got.payload !== want.payload) begin
					$display("%0t: found_payload exp %h got %h", $time,
						want.payload, got.payload);
					errors++;
				end
				if (got.duration !== want.duration) begin
					$display("%0t: found_duration exp %h got %h", $time,
						want.duration, got.duration);
					errors++;
				end
				if (got.total !== want.total) begin
					$display("%0t: entry_total exp %0d got %0d", $time, want.total, got.total);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL keyed_record_list_engine");
			$finish;
		end
	end

	initial begin
		row_t dir_rows[$];
		row_t op;
		logic [63:0] ones;
		ones = '1;
		errors = 0; cycles = 0; phase = 0; idle_pct = 0; stall_pct = 0; hold_left = -1;
		list_len = 0;
		for (int i = 0; i < CAPACITY; i++) begin
			list_key[i] = '0; list_pay[i] = '0; list_dur[i] = '0;
		end
		for (int i = 0; i < KEY_POOL; i++) key_pool[i] = (i < 4) ? 32'(i) : $urandom;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		dir_rows.push_back(mkx(mk(MODE_READ, 0, 0, 0, 0, 0), ST_BADPOS, 0, 0, 0, 0));
		dir_rows.push_back(mkx(mk(MODE_DELETE, 0, 0, 0, 0, 0), ST_NOKEY, 0, 0, 0, 0));
		dir_rows.push_back(mkx(mk(MODE_SORT, 0, 0, 0, 0, 0), ST_OK, 0, 0, 0, 0));
		dir_rows.push_back(mkx(mk(MODE_SPARE, 0, 0, 0, 0, 0), ST_OK, 0, 0, 0, 0));
		dir_rows.push_back(mkx(mk(3'd7, 7'h7f, '1, '1, ones, '1), ST_OK, 0, 0, 0, 0));
		dir_rows.push_back(mkx(mk(MODE_APPEND, 0, 0, 0, 0, 0), ST_OK, 0, 0, 0, 1));
		dir_rows.push_back(mkx(mk(MODE_APPEND, 7'h7f, '1, '1, ones, '1), ST_OK, 0, 0, 0, 2));
		dir_rows.push_back(mkx(mk(MODE_READ, 1, 0, 0, 0, 0), ST_OK, '1, ones, 0, 2));
		dir_rows.push_back(mkx(mk(MODE_INSERT, 3, 9, 0, 0, 0), ST_BADPOS, 0, 0, 0, 2));
		dir_rows.push_back(mkx(mk(MODE_INSERT, 7'h7f, 9, 0, 0, 0), ST_BADPOS, 0, 0, 0, 2));
		dir_rows.push_back(mkx(mk(MODE_APPEND, 0, 0, 0, 0, 0), ST_DUP, 0, 0, 0, 2));
		dir_rows.push_back(mkx(mk(MODE_INSERT, 0, '1, 0, 0, 0), ST_DUP, 0, 0, 0, 2));
		dir_rows.push_back(mkx(mk(MODE_INSERT, 0, 5, 0, 64'h55, 0), ST_OK, 0, 0, 0, 3));
		dir_rows.push_back(mkx(mk(MODE_MODIFY, 0, 5, 7, 64'h77, '1), ST_OK, 0, 0, 0, 3));
		dir_rows.push_back(mkx(mk(MODE_MODIFY, 0, 5, 8, 0, 0), ST_NOKEY, 0, 0, 0, 3));
		dir_rows.push_back(mk(MODE_READ, 0, 0, 0, 0, 0));
		dir_rows.push_back(mkx(mk(MODE_SORT, 0, 0, 0, 0, 0), ST_OK, 0, 0, 0, 3));
		dir_rows.push_back(mkx(mk(MODE_READ, 2, 0, 0, 0, 0), ST_OK, 7, 64'h77, '1, 3));
		dir_rows.push_back(mk(MODE_READ, 0, 0, 0, 0, 0));
		dir_rows.push_back(mkx(mk(MODE_READ, 3, 0, 0, 0, 0), ST_BADPOS, 0, 0, 0, 3));
		dir_rows.push_back(mkx(mk(MODE_DELETE, 0, 0, 0, 0, 0), ST_OK, 0, 0, 0, 2));
		dir_rows.push_back(mkx(mk(MODE_DELETE, 0, 0, 0, 0, 0), ST_NOKEY, 0, 0, 0, 2));
		dir_rows.push_back(mk(MODE_INSERT, 2, 32'h8000_0000, 0, 64'h8000_0000_0000_0000, 0));
		foreach (dir_rows[i]) send_op(dir_rows[i]);

		// fill to capacity, then the full-list cases
		while (list_len < CAPACITY) begin
			op = mk(MODE_APPEND, 0, $urandom, 0, {$urandom, $urandom}, 0);
			if (list_len % 3 == 0) op.mode = MODE_INSERT;
			op.pos = 7'($urandom_range(list_len));
			send_op(op);
			if (list_len % 2 == 1)
				send_op(mk(MODE_MODIFY, 0, list_key[list_len - 1], $urandom,
					{$urandom, $urandom}, 16'($urandom)));
		end
		send_op(mkx(mk(MODE_APPEND, 0, 32'h1234, 0, 0, 0), ST_FULL, 0, 0, 0, 64));
		send_op(mkx(mk(MODE_INSERT, 7'h7f, 32'h1234, 0, 0, 0), ST_FULL, 0, 0, 0, 64));
		send_op(mk(MODE_SORT, 0, 0, 0, 0, 0));
		send_op(mk(MODE_READ, 63, 0, 0, 0, 0));
		send_op(mkx(mk(MODE_READ, 64, 0, 0, 0, 0), ST_BADPOS, 0, 0, 0, 64));
		send_op(mk(MODE_DELETE, 0, list_key[63], 0, 0, 0));
		send_op(mk(MODE_DELETE, 0, list_key[0], 0, 0, 0));

		// random traffic in four phases of input idling and output stall
		for (int p = 0; p < 4; p++) begin
			phase = p;
			case (p)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 64; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 64; end
				default: begin idle_pct = 20; stall_pct = 20; end
			endcase
			for (int n = 0; n < RAND_PER_PHASE; n++) send_op(random_op());
		end
		@(posedge clk);
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("PASS keyed_record_list_engine");
		end else begin
			$display("FAIL keyed_record_list_engine");
		end
		$finish;
	end

endmodule
